/* src/line_follow_steering_control_core_defines.svh */
// Assertion macros shared by the steering control RTL.
`ifndef LINE_FOLLOW_STEERING_CONTROL_CORE_DEFINES_SVH
`define LINE_FOLLOW_STEERING_CONTROL_CORE_DEFINES_SVH

`ifndef SYNTH
`define LFSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfsc assertion failed");
`define LFSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfsc assertion failed");
`else
`define LFSC_ASSERT_IMP(lbl, ante, cons)
`define LFSC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/lfsc_pkg.sv */
// Types and constants for the line-follow steering control core.
package lfsc_pkg;

    localparam int ERR_W    = 8;
    localparam int SPD_W    = 14;
    localparam int LEFT_W   = 15;
    localparam int TURN_W   = 16;
    localparam int GAIN_W   = 9;
    localparam int SMOOTH_W = 7;
    localparam int LIMIT_W  = 8;
    localparam int SLOW_W   = 6;
    localparam int UPPER_W  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // serial multiplier / divider sizing
    localparam int MCAND_W = 17;
    localparam int MPLR_W  = 8;
    localparam int PROD_W  = MCAND_W + MPLR_W;
    localparam int DIVR_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_PCT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SLOW   = 2'd3;

    localparam logic [GAIN_W-1:0]   RST_STEER_GAIN  = 9'd260;
    localparam logic [SMOOTH_W-1:0] RST_SMOOTH_PCT  = 7'd3;
    localparam logic [LIMIT_W-1:0]  RST_ACCEL_LIMIT = 8'd150;
    localparam logic [SLOW_W-1:0]   RST_CURVE_SLOW  = 6'd15;

    localparam logic [MPLR_W-1:0] PCT_FULL  = 8'd100;
    localparam logic [DIVR_W-1:0] DIV_PCT   = 7'd100;
    localparam logic [DIVR_W-1:0] DIV_THIRD = 7'd3;

    localparam logic signed [ERR_W-1:0] ERR_DEAD = 8'sd2;

    localparam int TURN_MAX = 32767;
    localparam int TURN_MIN = -32768;
    localparam int LEFT_MAX = 32767;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD_MUL,
        ST_SPD_DIV,
        ST_ERR_MUL,
        ST_DIFF_MUL,
        ST_DIFF_DIV,
        ST_UP_MUL,
        ST_UP_DIV,
        ST_LO_DIV,
        ST_FIN
    } state_t;

endpackage

/* src/line_follow_steering_control_core.sv */
// Top level of the line-follow steering control core: sequencer and state.
//
// Input channel (in_valid/in_stall) carries one beat: line_error, speed_cmd.
// Output channel (out_valid/out_stall) returns one beat per input beat:
// left_drive, right_drive, turn_amount.
// Config: cfg_we/cfg_index/cfg_data write gain, smoothing, limit, slowdown;
// write only while no beat is in flight.
// One beat is worked at a time. in_stall is high from acceptance until the
// result is placed in the output register, and the curve slowdown adds a
// product and a quotient to the work. A shared bit-serial multiplier and a
// shared restoring divider, each started by a registered launch, do the
// arithmetic. A new beat is taken only after the last one is in the output
// register, and not while out_stall keeps it from getting there.
// The output register holds a finished beat while out_stall is high; a new
// input beat is taken meanwhile, and it waits at the end for the register.
// Reset restores the default register values, clears the filtered turn and
// drops out_valid.
`include "line_follow_steering_control_core_defines.svh"

module line_follow_steering_control_core
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [lfsc_pkg::ERR_W-1:0]       line_error,
    input  logic [lfsc_pkg::SPD_W-1:0]              speed_cmd,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [lfsc_pkg::LEFT_W-1:0]             left_drive,
    output logic signed [lfsc_pkg::LEFT_W-1:0]      right_drive,
    output logic signed [lfsc_pkg::TURN_W-1:0]      turn_amount,
    input  logic                                    cfg_we,
    input  logic [lfsc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int ERR_W  = lfsc_pkg::ERR_W;
    localparam int SPD_W  = lfsc_pkg::SPD_W;
    localparam int TURN_W = lfsc_pkg::TURN_W;
    localparam int LEFT_W = lfsc_pkg::LEFT_W;
    localparam int MW     = lfsc_pkg::MCAND_W;
    localparam int QW     = lfsc_pkg::MPLR_W;
    localparam int NW     = lfsc_pkg::PROD_W;
    localparam int DW     = lfsc_pkg::DIVR_W;
    localparam int UW     = lfsc_pkg::UPPER_W;
    localparam int SUM_W  = MW + 2;
    localparam int LS_W   = UW + 2;

    localparam logic signed [SUM_W-1:0] SUM_HI  = SUM_W'(lfsc_pkg::TURN_MAX);
    localparam logic signed [SUM_W-1:0] SUM_LO  = SUM_W'(lfsc_pkg::TURN_MIN);
    localparam logic signed [LS_W-1:0]  LEFT_HI = LS_W'(lfsc_pkg::LEFT_MAX);

    lfsc_pkg::state_t state_reg, state_next;
    logic launch_reg, launch_next;

    logic [lfsc_pkg::GAIN_W-1:0]   gain_reg;
    logic [lfsc_pkg::SMOOTH_W-1:0] smooth_reg;
    logic [lfsc_pkg::LIMIT_W-1:0]  limit_reg;
    logic [lfsc_pkg::SLOW_W-1:0]   slow_pct_reg;

    logic signed [TURN_W-1:0] filt_reg;
    logic                     slow_reg;
    logic                     out_valid_reg;

    logic signed [ERR_W-1:0]  err_reg;
    logic [SPD_W-1:0]         base_reg;
    logic [SPD_W-1:0]         spd_reg;
    logic                     diff_neg_reg;
    logic [UW-1:0]            upper_reg;
    logic [LEFT_W-1:0]        left_reg;
    logic [LEFT_W-1:0]        right_reg;
    logic [TURN_W-1:0]        turn_reg;

    logic accept;
    logic slow_in;
    logic out_load;
    logic mul_start;
    logic div_start;

    lfsc_pkg::unit_stat_t mul_st;
    lfsc_pkg::unit_stat_t div_st;
    logic [MW-1:0] mul_mcand;
    logic [QW-1:0] mul_mplier;
    logic [NW-1:0] mul_product;
    logic [NW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic [NW-1:0] div_quotient;

    logic [ERR_W-1:0]          err_mag;
    logic signed [MW:0]        prod_s;
    logic signed [MW:0]        diff;
    logic [MW:0]               diff_abs;
    logic signed [MW:0]        delta;
    logic signed [SUM_W-1:0]   turn_sum;
    logic signed [TURN_W-1:0]  filt_next;
    logic signed [LS_W-1:0]    left_sum;
    logic signed [LS_W-1:0]    upper_s;
    logic signed [LS_W-1:0]    lower_s;
    logic signed [LS_W-1:0]    left_c1;
    logic signed [LS_W-1:0]    left_c2;
    logic [LEFT_W-1:0]         left_next;
    logic [LEFT_W-1:0]         right_next;

    assign slow_in = (slow_pct_reg != '0) &&
                     ((line_error > lfsc_pkg::ERR_DEAD) || (line_error < -lfsc_pkg::ERR_DEAD));
    assign accept  = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfsc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = slow_in ? lfsc_pkg::ST_SPD_MUL : lfsc_pkg::ST_ERR_MUL;
                end
            end
            lfsc_pkg::ST_SPD_MUL:  if (mul_st.done) state_next = lfsc_pkg::ST_SPD_DIV;
            lfsc_pkg::ST_SPD_DIV:  if (div_st.done) state_next = lfsc_pkg::ST_ERR_MUL;
            lfsc_pkg::ST_ERR_MUL:  if (mul_st.done) state_next = lfsc_pkg::ST_DIFF_MUL;
            lfsc_pkg::ST_DIFF_MUL: if (mul_st.done) state_next = lfsc_pkg::ST_DIFF_DIV;
            lfsc_pkg::ST_DIFF_DIV: if (div_st.done) state_next = lfsc_pkg::ST_UP_MUL;
            lfsc_pkg::ST_UP_MUL:   if (mul_st.done) state_next = lfsc_pkg::ST_UP_DIV;
            lfsc_pkg::ST_UP_DIV:   if (div_st.done) state_next = lfsc_pkg::ST_LO_DIV;
            lfsc_pkg::ST_LO_DIV:   if (div_st.done) state_next = lfsc_pkg::ST_FIN;
            lfsc_pkg::ST_FIN:      if (out_load) state_next = lfsc_pkg::ST_IDLE;
            default:               state_next = lfsc_pkg::ST_IDLE;
        endcase
    end

    assign launch_next = (state_next != state_reg) &&
                         (state_next != lfsc_pkg::ST_IDLE) &&
                         (state_next != lfsc_pkg::ST_FIN);

    // state outputs
    always_comb
    begin
        in_stall  = (state_reg != lfsc_pkg::ST_IDLE);
        mul_start = launch_reg && (state_reg inside {lfsc_pkg::ST_SPD_MUL, lfsc_pkg::ST_ERR_MUL,
                                                     lfsc_pkg::ST_DIFF_MUL, lfsc_pkg::ST_UP_MUL});
        div_start = launch_reg && (state_reg inside {lfsc_pkg::ST_SPD_DIV, lfsc_pkg::ST_DIFF_DIV,
                                                     lfsc_pkg::ST_UP_DIV, lfsc_pkg::ST_LO_DIV});
        out_load  = (state_reg == lfsc_pkg::ST_FIN) && (!out_valid_reg || !out_stall);
    end

    // turn filter arithmetic, sign-magnitude around the unsigned units
    always_comb
    begin
        err_mag   = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
        prod_s    = err_reg[ERR_W-1] ? -$signed({1'b0, mul_product[MW-1:0]})
                                     :  $signed({1'b0, mul_product[MW-1:0]});
        diff      = prod_s - (MW+1)'(filt_reg);
        diff_abs  = diff[MW] ? (MW+1)'(-diff) : (MW+1)'(diff);
        delta     = diff_neg_reg ? -$signed({1'b0, div_quotient[MW-1:0]})
                                 :  $signed({1'b0, div_quotient[MW-1:0]});
        turn_sum  = SUM_W'(filt_reg) + SUM_W'(delta);
        if (turn_sum > SUM_HI)
        begin
            filt_next = SUM_HI[TURN_W-1:0];
        end
        else if (turn_sum < SUM_LO)
        begin
            filt_next = SUM_LO[TURN_W-1:0];
        end
        else
        begin
            filt_next = turn_sum[TURN_W-1:0];
        end
    end

    // left duty clamps
    always_comb
    begin
        left_sum   = $signed({{(LS_W-SPD_W){1'b0}}, spd_reg}) + LS_W'(filt_reg);
        upper_s    = $signed({2'b00, upper_reg});
        lower_s    = $signed({{(LS_W-SPD_W){1'b0}}, div_quotient[SPD_W-1:0]});
        left_c1    = (left_sum > upper_s) ? upper_s : left_sum;
        left_c2    = (left_c1 < lower_s) ? lower_s : left_c1;
        left_next  = (left_c2 > LEFT_HI) ? LEFT_HI[LEFT_W-1:0] : left_c2[LEFT_W-1:0];
        right_next = LEFT_W'(-{1'b0, spd_reg});
    end

    // operand selection
    always_comb
    begin
        mul_mcand    = '0;
        mul_mplier   = '0;
        div_dividend = mul_product;
        div_divisor  = lfsc_pkg::DIV_PCT;
        case (state_reg)
            lfsc_pkg::ST_SPD_MUL:
            begin
                mul_mcand  = MW'(base_reg);
                mul_mplier = lfsc_pkg::PCT_FULL - QW'(slow_pct_reg);
            end
            lfsc_pkg::ST_ERR_MUL:
            begin
                mul_mcand  = MW'(gain_reg);
                mul_mplier = QW'(err_mag);
            end
            lfsc_pkg::ST_DIFF_MUL:
            begin
                mul_mcand  = diff_abs[MW-1:0];
                mul_mplier = QW'(smooth_reg);
            end
            lfsc_pkg::ST_UP_MUL:
            begin
                mul_mcand  = MW'(spd_reg);
                mul_mplier = QW'(limit_reg);
            end
            lfsc_pkg::ST_LO_DIV:
            begin
                div_dividend = NW'(spd_reg);
                div_divisor  = lfsc_pkg::DIV_THIRD;
            end
            default:
            begin
                mul_mcand = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfsc_pkg::ST_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            slow_reg      <= 1'b0;
            gain_reg      <= lfsc_pkg::RST_STEER_GAIN;
            smooth_reg    <= lfsc_pkg::RST_SMOOTH_PCT;
            limit_reg     <= lfsc_pkg::RST_ACCEL_LIMIT;
            slow_pct_reg  <= lfsc_pkg::RST_CURVE_SLOW;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                slow_reg <= slow_in;
            end
            if (launch_reg && (state_reg == lfsc_pkg::ST_UP_MUL))
            begin
                filt_reg <= filt_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    lfsc_pkg::REG_STEER_GAIN:  gain_reg     <= cfg_data[lfsc_pkg::GAIN_W-1:0];
                    lfsc_pkg::REG_SMOOTH_PCT:  smooth_reg   <= cfg_data[lfsc_pkg::SMOOTH_W-1:0];
                    lfsc_pkg::REG_ACCEL_LIMIT: limit_reg    <= cfg_data[lfsc_pkg::LIMIT_W-1:0];
                    lfsc_pkg::REG_CURVE_SLOW:  slow_pct_reg <= cfg_data[lfsc_pkg::SLOW_W-1:0];
                    default:                   gain_reg     <= gain_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg  <= line_error;
            base_reg <= speed_cmd;
            spd_reg  <= speed_cmd;
        end
        if (launch_reg && (state_reg == lfsc_pkg::ST_ERR_MUL) && slow_reg)
        begin
            spd_reg <= div_quotient[SPD_W-1:0];
        end
        if (launch_reg && (state_reg == lfsc_pkg::ST_DIFF_MUL))
        begin
            diff_neg_reg <= diff[MW];
        end
        if (launch_reg && (state_reg == lfsc_pkg::ST_LO_DIV))
        begin
            upper_reg <= div_quotient[UW-1:0];
        end
        if (out_load)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            turn_reg  <= filt_reg;
        end
    end

    lfsc_serial_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .stat    (mul_st),
        .product (mul_product)
    );

    lfsc_serial_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_st),
        .quotient (div_quotient)
    );

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign turn_amount = turn_reg;

    `LFSC_ASSERT_IMP(a_one_unit_busy, mul_st.busy, !div_st.busy)
    `LFSC_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != lfsc_pkg::ST_IDLE)
    `LFSC_ASSERT_NXT(a_result_loaded, out_load, out_valid_reg)

endmodule

/* src/lfsc_serial_mul.sv */
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
`include "line_follow_steering_control_core_defines.svh"

module lfsc_serial_mul
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [lfsc_pkg::MCAND_W-1:0]        mcand,
    input  logic [lfsc_pkg::MPLR_W-1:0]         mplier,
    output lfsc_pkg::unit_stat_t                stat,
    output logic [lfsc_pkg::PROD_W-1:0]         product
);

    localparam int MW    = lfsc_pkg::MCAND_W;
    localparam int QW    = lfsc_pkg::MPLR_W;
    localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MW-1:0]    acc_reg;
    logic [QW-1:0]    q_reg;
    logic [MW-1:0]    mcand_reg;
    logic [MW:0]      sum;

    assign sum = {1'b0, acc_reg} + (q_reg[0] ? {1'b0, mcand_reg} : {(MW+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            q_reg     <= mplier;
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum[MW:1];
            q_reg   <= {sum[0], q_reg[QW-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == CNT_LAST);
    assign product   = {acc_reg, q_reg};

    `LFSC_ASSERT_IMP(a_mul_start_idle, start, !busy_reg)
    `LFSC_ASSERT_NXT(a_mul_start_busy, start, busy_reg)
    `LFSC_ASSERT_NXT(a_mul_done_free, busy_reg && (cnt_reg == CNT_LAST), !busy_reg)

endmodule

/* src/lfsc_serial_div.sv */
// Restoring divider by a small constant, one quotient bit per cycle.
`include "line_follow_steering_control_core_defines.svh"

module lfsc_serial_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [lfsc_pkg::PROD_W-1:0]         dividend,
    input  logic [lfsc_pkg::DIVR_W-1:0]         divisor,
    output lfsc_pkg::unit_stat_t                stat,
    output logic [lfsc_pkg::PROD_W-1:0]         quotient
);

    localparam int NW    = lfsc_pkg::PROD_W;
    localparam int DW    = lfsc_pkg::DIVR_W;
    localparam int RW    = DW + 1;
    localparam int CNT_W = $clog2(NW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    divisor_reg;
    logic [RW-1:0]    trial;
    logic             fits;
    logic [RW-1:0]    rem_next;

    always_comb
    begin
        trial    = {rem_reg[RW-2:0], quo_reg[NW-1]};
        fits     = trial >= {1'b0, divisor_reg};
        rem_next = fits ? (trial - {1'b0, divisor_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == CNT_LAST);
    assign quotient  = quo_reg;

    `LFSC_ASSERT_IMP(a_div_start_idle, start, !busy_reg)
    `LFSC_ASSERT_NXT(a_div_start_busy, start, busy_reg)
    `LFSC_ASSERT_NXT(a_div_done_free, busy_reg && (cnt_reg == CNT_LAST), !busy_reg)

endmodule

/* tb/sv/tb_line_follow_steering_control_core.sv */
// Self-checking testbench for the line-follow steering control core.
module tb_line_follow_steering_control_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lfsc_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 200;
    localparam int DIR_ROWS    = 37;

    typedef struct packed {
        logic [LEFT_W-1:0]        left;
        logic signed [LEFT_W-1:0] right;
        logic signed [TURN_W-1:0] turn;
    } duty_beat_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        logic signed [ERR_W-1:0]  err;
        logic [SPD_W-1:0]         spd;
        bit                       typed;
        logic [LEFT_W-1:0]        w_left;
        logic signed [LEFT_W-1:0] w_right;
        logic signed [TURN_W-1:0] w_turn;
    } dir_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic signed [ERR_W-1:0]     line_error = '0;
    logic [SPD_W-1:0]            speed_cmd = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [LEFT_W-1:0]           left_drive;
    logic signed [LEFT_W-1:0]    right_drive;
    logic signed [TURN_W-1:0]    turn_amount;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    // predictor copy of the block's registers and filter state
    logic [GAIN_W-1:0]           gain_cfg = RST_STEER_GAIN;
    logic [SMOOTH_W-1:0]         smooth_cfg = RST_SMOOTH_PCT;
    logic [LIMIT_W-1:0]          limit_cfg = RST_ACCEL_LIMIT;
    logic [SLOW_W-1:0]           slow_cfg = RST_CURVE_SLOW;
    logic signed [TURN_W-1:0]    filt_turn = '0;

    duty_beat_t                  pending_duties[$];
    int                          mismatches = 0;
    int                          stuck_cycles = 0;
    int                          stall_hold = 0;
    bit                          calm = 1'b0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd0,    14'd0,     1'b1, 15'd0, 15'sd0, 16'sd0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd0,    14'd9000,  1'b1, 15'd9000, -15'sd9000,
          16'sd0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd0,    14'd16383, 1'b1, 15'd16383, -15'sd16383,
          16'sd0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd2,    14'd16383, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd2,   14'd10000, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd3,    14'd10000, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd3,   14'd10000, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd127,  14'd16383, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd128, 14'd16383, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd100,  14'd10000, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd100, 14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_STEER_GAIN, 9'd511, 8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_SMOOTH_PCT, 9'd127, 8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_CURVE_SLOW, 9'd0,   8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_ACCEL_LIMIT, 9'd255, 8'sd0,   14'd0,     1'b0, '0, '0, '0},
        // turn saturates, left duty saturates
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd127,  14'd16383, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd127,  14'd16383, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd128, 14'd16383, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd128, 14'd0,     1'b0, '0, '0, '0},
        // upper clamp below one third
        '{ROW_CFG,  REG_ACCEL_LIMIT, 9'd0,  8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd50,   14'd12000, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd50,  14'd12000, 1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_CURVE_SLOW, 9'd63,  8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_SMOOTH_PCT, 9'd0,   8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_STEER_GAIN, 9'd0,   8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd100,  14'd16383, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd1,    14'd16383, 1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_CURVE_SLOW, 9'd50,  8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_SMOOTH_PCT, 9'd100, 8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_STEER_GAIN, 9'd320, 8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_ACCEL_LIMIT, 9'd100, 8'sd0,   14'd0,     1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd100,  14'd10000, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd100, 14'd10000, 1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_ACCEL_LIMIT, 9'd200, 8'sd0,   14'd0,     1'b0, '0, '0, '0},
        '{ROW_CFG,  REG_CURVE_SLOW, 9'd1,   8'sd0,    14'd0,     1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   8'sd5,    14'd8191,  1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_STEER_GAIN, 9'd0,   -8'sd1,   14'd1,     1'b0, '0, '0, '0}
    };

    line_follow_steering_control_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .line_error  (line_error),
        .speed_cmd   (speed_cmd),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .turn_amount (turn_amount),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic duty_beat_t steer_predict(input logic signed [ERR_W-1:0] err,
                                                 input logic [SPD_W-1:0] spd);
        duty_beat_t res;
        longint e, s, f, d, g, sm, lim, sl, mag, left, upper, lower, neg;
        e   = err;
        s   = spd;
        f   = filt_turn;
        g   = gain_cfg;
        sm  = smooth_cfg;
        lim = limit_cfg;
        sl  = slow_cfg;
        mag = (e < 0) ? -e : e;
        if (sl != 0 && mag > 2)
            s = s * (100 - sl) / 100;
        d = e * g - f;
        f = f + d * sm / 100;
        if (f > TURN_MAX)
            f = TURN_MAX;
        if (f < TURN_MIN)
            f = TURN_MIN;
        filt_turn = f[TURN_W-1:0];
        left  = s + f;
        upper = s * lim / 100;
        lower = s / 3;
        if (left > upper)
            left = upper;
        if (left < lower)
            left = lower;
        if (left > LEFT_MAX)
            left = LEFT_MAX;
        neg = -s;
        res.left  = left[LEFT_W-1:0];
        res.right = neg[LEFT_W-1:0];
        res.turn  = f[TURN_W-1:0];
        return res;
    endfunction

    task automatic send_item(input logic signed [ERR_W-1:0] err, input logic [SPD_W-1:0] spd,
                             input bit typed, input duty_beat_t want);
        duty_beat_t pred;
        @(negedge clk);
        in_valid   <= 1'b1;
        line_error <= err;
        speed_cmd  <= spd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = steer_predict(err, spd);
        pending_duties.push_back(typed ? want : pred);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STEER_GAIN:  gain_cfg   = val[GAIN_W-1:0];
            REG_SMOOTH_PCT:  smooth_cfg = val[SMOOTH_W-1:0];
            REG_ACCEL_LIMIT: limit_cfg  = val[LIMIT_W-1:0];
            REG_CURVE_SLOW:  slow_cfg   = val[SLOW_W-1:0];
            default: ;
        endcase
    endtask

    always @(negedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (stall_hold > 0)
            stall_hold--;
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    out_stall <= 1'b1;
                    stall_hold = $urandom_range(0, 11);
                end
                1:
                begin
                    out_stall <= 1'b0;
                    stall_hold = $urandom_range(20, 200);
                end
                default:
                begin
                    out_stall <= 1'b0;
                    stall_hold = $urandom_range(0, 11);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        duty_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_duties.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: left %0d right %0d turn %0d",
                             left_drive, right_drive, turn_amount);
            end
            else
            begin
                want = pending_duties.pop_front();
                if (left_drive !== want.left || right_drive !== want.right
                    || turn_amount !== want.turn)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch (exp/got): left %0d/%0d right %0d/%0d turn %0d/%0d",
                                 want.left, left_drive, want.right, right_drive,
                                 want.turn, turn_amount);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb_line_follow_steering_control_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        int ph, k, e_i, s_i, bias, run_left;
        int g, sm, lim, sl;
        duty_beat_t want;
        bias     = 0;
        run_left = 0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                drain_results();
                cfg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end
            else
            begin
                want.left  = dir_tab[i].w_left;
                want.right = dir_tab[i].w_right;
                want.turn  = dir_tab[i].w_turn;
                sender_gap();
                send_item(dir_tab[i].err, dir_tab[i].spd, dir_tab[i].typed, want);
            end
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    g = 0; sm = 0; lim = 100; sl = 0;
                end
                1:
                begin
                    g = 320; sm = 100; lim = 200; sl = 50;
                end
                2:
                begin
                    g = 511; sm = 127; lim = 255; sl = 63;
                end
                3:
                begin
                    g = 0; sm = 0; lim = 0; sl = 0;
                end
                PHASES - 1:
                begin
                    g = RST_STEER_GAIN; sm = RST_SMOOTH_PCT;
                    lim = RST_ACCEL_LIMIT; sl = RST_CURVE_SLOW;
                end
                default:
                begin
                    g   = $urandom_range(0, 320);
                    sm  = $urandom_range(0, 100);
                    lim = $urandom_range(100, 200);
                    sl  = $urandom_range(0, 50);
                end
            endcase
            drain_results();
            cfg_write(REG_STEER_GAIN, g[CFG_DATA_W-1:0]);
            cfg_write(REG_SMOOTH_PCT, sm[CFG_DATA_W-1:0]);
            cfg_write(REG_ACCEL_LIMIT, lim[CFG_DATA_W-1:0]);
            cfg_write(REG_CURVE_SLOW, sl[CFG_DATA_W-1:0]);
            calm = (ph == PHASES - 1);

            for (k = 0; k < PHASE_BEATS; k++)
            begin
                // curves: runs of errors around a common offset
                if (run_left == 0)
                begin
                    bias     = int'($urandom_range(0, 200)) - 100;
                    run_left = $urandom_range(5, 40);
                end
                run_left--;
                case ($urandom_range(0, 9))
                    0: e_i = int'($urandom_range(0, 255)) - 128;
                    1: e_i = int'($urandom_range(0, 4)) - 2;
                    default:
                    begin
                        e_i = bias + int'($urandom_range(0, 20)) - 10;
                        if (e_i > 127)
                            e_i = 127;
                        if (e_i < -128)
                            e_i = -128;
                    end
                endcase
                case ($urandom_range(0, 9))
                    0: s_i = $urandom_range(0, 16383);
                    1: s_i = $urandom_range(0, 20);
                    default: s_i = $urandom_range(0, 10000);
                endcase
                if (ph == 5 && k == PHASE_BEATS / 2)
                    drain_results();
                sender_gap();
                send_item(e_i[ERR_W-1:0], s_i[SPD_W-1:0], 1'b0, '0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        if (mismatches == 0 && pending_duties.size() == 0)
            $display("tb_line_follow_steering_control_core: done, clean");
        else
            $display("tb_line_follow_steering_control_core: done, errors");
        $finish;
    end

endmodule
